// File: rtl/hfe_pkg.sv
package hfe_pkg;

    // defaults for the top level parameters and register resets
    localparam int MAX_WIDTH   = 64;
    localparam int MAX_ROWS    = 64;
    localparam int STORE_DEPTH_DEF = 4096;
    localparam int QUEUE_DEPTH = 2;

    // datapath widths
    localparam int CW     = 12;   // signed corner coordinate
    localparam int OFF_W  = 10;   // corner offset from the rectangle origin
    localparam int IDX_W  = 20;   // signed linear store index
    localparam int NUM_W  = 41;   // signed feature sum
    localparam int MAG_W  = 40;   // magnitude of the feature sum
    localparam int FRAC_W = 16;
    localparam int DVD_W  = MAG_W + FRAC_W;
    localparam int PROD_W = 16;
    localparam int AREA_W = 20;
    localparam int Q_W    = 32;
    localparam int CNT_W  = 5;

    typedef enum logic [3:0] {
        OP_LOAD   = 4'd0,
        OP_X2     = 4'd1,
        OP_Y2     = 4'd2,
        OP_X3     = 4'd3,
        OP_Y3     = 4'd4,
        OP_X4     = 4'd5,
        OP_Y4     = 4'd6,
        OP_CENTER = 4'd7,
        OP_X2Y2   = 4'd8
    } opcode_t;

    typedef enum logic {
        CFG_ROW_STRIDE  = 1'b0,
        CFG_ROWS_IN_USE = 1'b1
    } cfg_index_t;

    // corner offset select: multiples of the split step, or the full span
    typedef enum logic [2:0] {
        SEL_0    = 3'd0,
        SEL_A1   = 3'd1,
        SEL_A2   = 3'd2,
        SEL_A3   = 3'd3,
        SEL_A4   = 3'd4,
        SEL_SPAN = 3'd5
    } sel_t;

    typedef enum logic [2:0] {
        WT_P1 = 3'd0,
        WT_M1 = 3'd1,
        WT_P2 = 3'd2,
        WT_M2 = 3'd3,
        WT_M9 = 3'd4
    } wt_t;

    typedef enum logic [1:0] {
        K1 = 2'd0,
        K2 = 2'd1,
        K4 = 2'd2,
        K9 = 2'd3
    } kmul_t;

    typedef struct packed {
        sel_t x0;
        sel_t x1;
        sel_t y0;
        sel_t y1;
        wt_t  wt;
    } box_t;

    // classified item handed from the front end to the back end
    typedef struct packed {
        logic                 is_load;
        opcode_t              op;
        logic [11:0]          load_index;
        logic [31:0]          load_value;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic [7:0]           w;
        logic [7:0]           h;
        logic [7:0]           ax;
        logic [7:0]           ay;
        logic [7:0]           m1;
        logic [7:0]           m2;
        kmul_t                kmul;
        logic [1:0]           nbox;
    } cmd_t;

    // floor(v / 3) for 8-bit values via reciprocal multiply
    function automatic logic [7:0] div3(logic [7:0] v);
        logic [16:0] p;
        p = {9'd0, v} * 17'd171;
        return p[16:9];
    endfunction

    function automatic logic [OFF_W-1:0] sel_offset(sel_t s, logic [7:0] a, logic [7:0] span);
        logic [OFF_W-1:0] a1;
        a1 = {2'b00, a};
        unique case (s)
            SEL_0:    return '0;
            SEL_A1:   return a1;
            SEL_A2:   return a1 << 1;
            SEL_A3:   return (a1 << 1) + a1;
            SEL_A4:   return a1 << 2;
            SEL_SPAN: return {2'b00, span};
            default:  return '0;
        endcase
    endfunction

    function automatic box_t mk_box(sel_t x0, sel_t x1, sel_t y0, sel_t y1, wt_t wt);
        box_t b;
        b.x0 = x0;
        b.x1 = x1;
        b.y0 = y0;
        b.y1 = y1;
        b.wt = wt;
        return b;
    endfunction

    // box k of a feature type
    function automatic box_t box_desc(opcode_t op, logic [1:0] k);
        box_t d;
        d = mk_box(SEL_0, SEL_0, SEL_0, SEL_0, WT_P1);
        unique case (op)
            OP_X2:
                d = (k == 2'd0) ? mk_box(SEL_0, SEL_SPAN, SEL_0, SEL_A1, WT_P1)
                                : mk_box(SEL_0, SEL_SPAN, SEL_A1, SEL_A2, WT_M1);
            OP_Y2:
                d = (k == 2'd0) ? mk_box(SEL_0, SEL_A1, SEL_0, SEL_SPAN, WT_P1)
                                : mk_box(SEL_A1, SEL_A2, SEL_0, SEL_SPAN, WT_M1);
            OP_X3:
                d = (k == 2'd0) ? mk_box(SEL_0, SEL_SPAN, SEL_A2, SEL_A3, WT_P1)
                  : (k == 2'd1) ? mk_box(SEL_0, SEL_SPAN, SEL_0, SEL_A1, WT_P1)
                                : mk_box(SEL_0, SEL_SPAN, SEL_A1, SEL_A2, WT_M2);
            OP_Y3:
                d = (k == 2'd0) ? mk_box(SEL_0, SEL_A1, SEL_0, SEL_SPAN, WT_P1)
                  : (k == 2'd1) ? mk_box(SEL_A2, SEL_A3, SEL_0, SEL_SPAN, WT_P1)
                                : mk_box(SEL_A1, SEL_A2, SEL_0, SEL_SPAN, WT_M2);
            OP_X4:
                d = (k == 2'd0) ? mk_box(SEL_0, SEL_SPAN, SEL_0, SEL_A1, WT_P1)
                  : (k == 2'd1) ? mk_box(SEL_0, SEL_SPAN, SEL_A3, SEL_A4, WT_P1)
                                : mk_box(SEL_0, SEL_SPAN, SEL_A1, SEL_A3, WT_M1);
            OP_Y4:
                d = (k == 2'd0) ? mk_box(SEL_0, SEL_A1, SEL_0, SEL_SPAN, WT_P1)
                  : (k == 2'd1) ? mk_box(SEL_A3, SEL_A4, SEL_0, SEL_SPAN, WT_P1)
                                : mk_box(SEL_A1, SEL_A3, SEL_0, SEL_SPAN, WT_M1);
            OP_CENTER:
                d = (k == 2'd0) ? mk_box(SEL_0, SEL_A3, SEL_0, SEL_A3, WT_P1)
                                : mk_box(SEL_A1, SEL_A2, SEL_A1, SEL_A2, WT_M9);
            OP_X2Y2:
                d = (k == 2'd0) ? mk_box(SEL_0, SEL_A2, SEL_0, SEL_A2, WT_P1)
                  : (k == 2'd1) ? mk_box(SEL_A1, SEL_A2, SEL_A1, SEL_A2, WT_M2)
                                : mk_box(SEL_0, SEL_A1, SEL_0, SEL_A1, WT_M2);
            default:
                d = mk_box(SEL_0, SEL_0, SEL_0, SEL_0, WT_P1);
        endcase
        return d;
    endfunction

endpackage

// File: rtl/haar_feature_eval.sv
// haar feature evaluation on a stored integral image
// load transaction: written to the store in the same cycle that it leaves the input queue
// query transaction: two-box or three-box features, each corner read in three steps
// (S_ADDR, S_READ, S_ACC on the single store port), then a 32-step divider
// reset (rst_n low, asynchronous) empties both queues, idles the back end and sets
// row_stride and rows_in_use to 64; store contents are undefined until loaded
module haar_feature_eval #(
    parameter int STORE_DEPTH = hfe_pkg::STORE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // input queue side
    input  logic        push,
    output logic        full,
    input  logic [3:0]  opcode,
    input  logic [11:0] load_index,
    input  logic [31:0] load_value,
    input  logic [7:0]  rect_x,
    input  logic [7:0]  rect_y,
    input  logic [7:0]  rect_width,
    input  logic [7:0]  rect_height,
    // result queue side
    output logic        empty,
    input  logic        pop,
    output logic [31:0] feature_value,
    output logic        zero_area,
    // configuration writes
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [6:0]  cfg_data
);

    import hfe_pkg::*;

    localparam int AW    = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int RES_W = 33;

    // configuration registers
    logic [6:0] stride_reg, stride_next;
    logic [6:0] rows_reg, rows_next;

    always_comb
    begin
        stride_next = stride_reg;
        rows_next   = rows_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_ROW_STRIDE:  stride_next = cfg_data;
                CFG_ROWS_IN_USE: rows_next   = cfg_data;
                default:         stride_next = stride_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stride_reg <= 7'(MAX_WIDTH);
            rows_reg   <= 7'(MAX_ROWS);
        end
        else
        begin
            stride_reg <= stride_next;
            rows_reg   <= rows_next;
        end
    end

    // front end: classify the transaction and precompute split steps and area factors
    cmd_t cmd_in, cmd_out;
    logic cmd_push, cmd_pop, cmd_empty;

    hfe_front #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_front (
        .push        (push),
        .q_full      (full),
        .opcode      (opcode),
        .load_index  (load_index),
        .load_value  (load_value),
        .rect_x      (rect_x),
        .rect_y      (rect_y),
        .rect_width  (rect_width),
        .rect_height (rect_height),
        .cmd_push    (cmd_push),
        .cmd         (cmd_in)
    );

    // short command queue decouples acceptance from execution; its full flag
    // is the input full, so loads and queries keep their order
    logic [$bits(cmd_t)-1:0] cmd_rdata;

    hfe_fifo #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cmd_push),
        .wdata (cmd_in),
        .full  (full),
        .pop   (cmd_pop),
        .rdata (cmd_rdata),
        .empty (cmd_empty)
    );

    assign cmd_out = cmd_t'(cmd_rdata);

    // integral image store, one port shared by loads and corner reads
    logic          ram_we, ram_re;
    logic [AW-1:0] ram_addr;
    logic [31:0]   ram_wdata, ram_rdata;

    hfe_ram #(
        .WIDTH (32),
        .DEPTH (STORE_DEPTH),
        .AW    (AW)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // back end: corner reads, weighted sum, area and fixed-point divide
    logic        res_full, res_push, res_zero;
    logic [31:0] res_value;

    hfe_back #(
        .STORE_DEPTH (STORE_DEPTH),
        .AW          (AW)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .cmd       (cmd_out),
        .stride    (stride_reg),
        .rows      (rows_reg),
        .ram_we    (ram_we),
        .ram_re    (ram_re),
        .ram_addr  (ram_addr),
        .ram_wdata (ram_wdata),
        .ram_rdata (ram_rdata),
        .res_full  (res_full),
        .res_push  (res_push),
        .res_value (res_value),
        .res_zero  (res_zero)
    );

    // result queue holds finished results while the consumer stalls
    logic [RES_W-1:0] res_rdata;

    hfe_fifo #(
        .WIDTH (RES_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata ({res_zero, res_value}),
        .full  (res_full),
        .pop   (pop),
        .rdata (res_rdata),
        .empty (empty)
    );

    assign zero_area     = res_rdata[RES_W-1];
    assign feature_value = res_rdata[31:0];

endmodule

// File: rtl/hfe_ram.sv
module hfe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic             re,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/hfe_fifo.sv
module hfe_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// File: rtl/hfe_front.sv
module hfe_front #(
    parameter int STORE_DEPTH = hfe_pkg::STORE_DEPTH_DEF
) (
    input  logic          push,
    input  logic          q_full,
    input  logic [3:0]    opcode,
    input  logic [11:0]   load_index,
    input  logic [31:0]   load_value,
    input  logic [7:0]    rect_x,
    input  logic [7:0]    rect_y,
    input  logic [7:0]    rect_width,
    input  logic [7:0]    rect_height,
    output logic          cmd_push,
    output hfe_pkg::cmd_t cmd
);

    import hfe_pkg::*;

    logic    keep;
    opcode_t op;

    assign op = opcode_t'(opcode);

    always_comb
    begin
        cmd            = '0;
        cmd.op         = op;
        cmd.load_index = load_index;
        cmd.load_value = load_value;
        cmd.x          = $signed({{(CW - 8){1'b0}}, rect_x}) - CW'(1);
        cmd.y          = $signed({{(CW - 8){1'b0}}, rect_y}) - CW'(1);
        cmd.w          = rect_width;
        cmd.h          = rect_height;
        cmd.nbox       = 2'd3;
        cmd.kmul       = K1;
        keep           = 1'b1;
        unique case (op)
            OP_LOAD:
            begin
                cmd.is_load = 1'b1;
                keep        = ({20'd0, load_index} < 32'(STORE_DEPTH));
            end
            OP_X2:
            begin
                cmd.ay   = rect_height >> 1;
                cmd.m1   = rect_width;
                cmd.m2   = rect_height >> 1;
                cmd.nbox = 2'd2;
            end
            OP_Y2:
            begin
                cmd.ax   = rect_width >> 1;
                cmd.m1   = rect_width >> 1;
                cmd.m2   = rect_height;
                cmd.nbox = 2'd2;
            end
            OP_X3:
            begin
                cmd.ay   = div3(rect_height);
                cmd.m1   = div3(rect_height);
                cmd.m2   = rect_width;
                cmd.kmul = K2;
            end
            OP_Y3:
            begin
                cmd.ax   = div3(rect_width);
                cmd.m1   = rect_height;
                cmd.m2   = div3(rect_width);
                cmd.kmul = K2;
            end
            OP_X4:
            begin
                cmd.ay   = rect_height >> 2;
                cmd.m1   = rect_width;
                cmd.m2   = rect_height >> 2;
                cmd.kmul = K2;
            end
            OP_Y4:
            begin
                cmd.ax   = rect_width >> 2;
                cmd.m1   = rect_height;
                cmd.m2   = rect_width >> 2;
                cmd.kmul = K2;
            end
            OP_CENTER:
            begin
                cmd.ax   = div3(rect_width);
                cmd.ay   = div3(rect_height);
                cmd.m1   = div3(rect_width);
                cmd.m2   = div3(rect_height);
                cmd.kmul = K9;
                cmd.nbox = 2'd2;
            end
            OP_X2Y2:
            begin
                cmd.ax   = rect_width >> 1;
                cmd.ay   = rect_height >> 1;
                cmd.m1   = rect_width >> 1;
                cmd.m2   = rect_height >> 1;
                cmd.kmul = K4;
            end
            default:
            begin
                keep = 1'b0;   // unused opcodes are dropped
            end
        endcase
    end

    assign cmd_push = push && !q_full && keep;

endmodule

// File: rtl/hfe_back.sv
module hfe_back #(
    parameter int STORE_DEPTH = hfe_pkg::STORE_DEPTH_DEF,
    parameter int AW          = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_empty,
    output logic          cmd_pop,
    input  hfe_pkg::cmd_t cmd,
    input  logic [6:0]    stride,
    input  logic [6:0]    rows,
    output logic          ram_we,
    output logic          ram_re,
    output logic [AW-1:0] ram_addr,
    output logic [31:0]   ram_wdata,
    input  logic [31:0]   ram_rdata,
    input  logic          res_full,
    output logic          res_push,
    output logic [31:0]   res_value,
    output logic          res_zero
);

    import hfe_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b00000001,
        S_ADDR  = 8'b00000010,
        S_READ  = 8'b00000100,
        S_ACC   = 8'b00001000,
        S_AREA  = 8'b00010000,
        S_SCALE = 8'b00100000,
        S_DIV   = 8'b01000000,
        S_DONE  = 8'b10000000
    } state_t;

    state_t                  state_reg, state_next;
    cmd_t                    cmd_reg, cmd_next;
    logic [1:0]              box_reg, box_next;
    logic [1:0]              crn_reg, crn_next;
    logic [AW-1:0]           idx_reg, idx_next;
    logic                    zc_reg, zc_next;
    logic signed [NUM_W-1:0] acc_reg, acc_next;
    logic [PROD_W-1:0]       prod_reg, prod_next;
    logic [DVD_W-1:0]        rem_reg, rem_next;
    logic [DVD_W-1:0]        ds_reg, ds_next;
    logic [Q_W-1:0]          q_reg, q_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic                    sat_reg, sat_next;
    logic                    neg_reg, neg_next;
    logic                    zero_reg, zero_next;

    // corner address path
    box_t                    desc;
    sel_t                    xsel, ysel;
    logic signed [CW-1:0]    px, py, row, col, s_s, h_s;
    logic signed [IDX_W-1:0] idx;
    logic                    corner_zero, oor;
    logic [AW-1:0]           addr_sel;

    // accumulate path
    logic [NUM_W-1:0]        val, scaled;
    logic                    term_neg, last_corner;

    // area and divide path
    logic [AREA_W-1:0]       area;
    logic [MAG_W-1:0]        mag;
    logic [DVD_W-1:0]        dvd, lim;
    logic                    ge;

    always_comb
    begin
        desc = box_desc(cmd_reg.op, box_reg);
        xsel = crn_reg[0] ? desc.x0 : desc.x1;
        ysel = (crn_reg[0] ^ crn_reg[1]) ? desc.y0 : desc.y1;
        px   = cmd_reg.x + $signed({2'b00, sel_offset(xsel, cmd_reg.ax, cmd_reg.w)});
        py   = cmd_reg.y + $signed({2'b00, sel_offset(ysel, cmd_reg.ay, cmd_reg.h)});
        s_s  = $signed({{(CW - 7){1'b0}}, stride});
        h_s  = $signed({{(CW - 7){1'b0}}, rows});
        corner_zero = (px <= 0) || (py <= 0);
        // clamp to the right edge or to the bottom row
        row  = ((px < s_s) && (py >= h_s)) ? (h_s - CW'(1)) : py;
        col  = ((px >= s_s) && (py < h_s)) ? (s_s - CW'(1)) : px;
        idx  = IDX_W'(row) * IDX_W'(s_s) + IDX_W'(col);
        oor  = (idx < 0) || (idx >= IDX_W'(STORE_DEPTH));
        addr_sel = oor ? AW'(STORE_DEPTH - 1) : idx[AW-1:0];
    end

    always_comb
    begin
        val = zc_reg ? '0 : {{(NUM_W - 32){1'b0}}, ram_rdata};
        unique case (desc.wt)
            WT_P1, WT_M1: scaled = val;
            WT_P2, WT_M2: scaled = val << 1;
            WT_M9:        scaled = (val << 3) + val;
            default:      scaled = val;
        endcase
        term_neg    = crn_reg[1] ^ ((desc.wt == WT_M1) || (desc.wt == WT_M2)
                                    || (desc.wt == WT_M9));
        last_corner = (crn_reg == 2'd3) && (box_reg == cmd_reg.nbox - 2'd1);
    end

    always_comb
    begin
        unique case (cmd_reg.kmul)
            K1:      area = AREA_W'(prod_reg);
            K2:      area = AREA_W'(prod_reg) << 1;
            K4:      area = AREA_W'(prod_reg) << 2;
            K9:      area = (AREA_W'(prod_reg) << 3) + AREA_W'(prod_reg);
            default: area = AREA_W'(prod_reg);
        endcase
        mag = acc_reg[NUM_W-1] ? MAG_W'(-acc_reg) : MAG_W'(acc_reg);
        dvd = {mag, {FRAC_W{1'b0}}};
        lim = DVD_W'(area) << 32;
        ge  = (rem_reg >= ds_reg);
    end

    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        box_next   = box_reg;
        crn_next   = crn_reg;
        idx_next   = idx_reg;
        zc_next    = zc_reg;
        acc_next   = acc_reg;
        prod_next  = prod_reg;
        rem_next   = rem_reg;
        ds_next    = ds_reg;
        q_next     = q_reg;
        cnt_next   = cnt_reg;
        sat_next   = sat_reg;
        neg_next   = neg_reg;
        zero_next  = zero_reg;
        cmd_pop    = 1'b0;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        ram_addr   = idx_reg;
        ram_wdata  = cmd.load_value;
        res_push   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                ram_addr = AW'(cmd.load_index);
                if (!cmd_empty)
                begin
                    cmd_pop = 1'b1;
                    if (cmd.is_load)
                    begin
                        ram_we = 1'b1;
                    end
                    else
                    begin
                        cmd_next   = cmd;
                        box_next   = '0;
                        crn_next   = '0;
                        acc_next   = '0;
                        state_next = S_ADDR;
                    end
                end
            end
            S_ADDR:
            begin
                idx_next   = addr_sel;
                zc_next    = corner_zero;
                state_next = S_READ;
            end
            S_READ:
            begin
                ram_re     = 1'b1;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                acc_next = term_neg ? (acc_reg - $signed(scaled)) : (acc_reg + $signed(scaled));
                crn_next = crn_reg + 2'd1;
                if (crn_reg == 2'd3)
                begin
                    box_next = box_reg + 2'd1;
                end
                state_next = last_corner ? S_AREA : S_ADDR;
            end
            S_AREA:
            begin
                prod_next  = cmd_reg.m1 * cmd_reg.m2;
                state_next = S_SCALE;
            end
            S_SCALE:
            begin
                zero_next = (area == '0);
                neg_next  = acc_reg[NUM_W-1];
                sat_next  = (dvd >= lim);
                rem_next  = dvd;
                ds_next   = DVD_W'(area) << 31;
                q_next    = '0;
                cnt_next  = CNT_W'(Q_W - 1);
                state_next = ((area == '0) || (dvd >= lim)) ? S_DONE : S_DIV;
            end
            S_DIV:
            begin
                rem_next = ge ? (rem_reg - ds_reg) : rem_reg;
                q_next   = {q_reg[Q_W-2:0], ge};
                ds_next  = ds_reg >> 1;
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!res_full)
                begin
                    res_push   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // zero area gives zero; otherwise saturate to the int32 limits, then apply the sign
    always_comb
    begin
        res_zero = zero_reg;
        if (zero_reg)
        begin
            res_value = '0;
        end
        else if (!neg_reg)
        begin
            res_value = (sat_reg || q_reg[Q_W-1]) ? 32'h7fff_ffff : q_reg;
        end
        else
        begin
            res_value = (sat_reg || (q_reg[Q_W-1] && (|q_reg[Q_W-2:0])))
                        ? 32'h8000_0000 : (~q_reg + 32'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        box_reg  <= box_next;
        crn_reg  <= crn_next;
        idx_reg  <= idx_next;
        zc_reg   <= zc_next;
        acc_reg  <= acc_next;
        prod_reg <= prod_next;
        rem_reg  <= rem_next;
        ds_reg   <= ds_next;
        q_reg    <= q_next;
        cnt_reg  <= cnt_next;
        sat_reg  <= sat_next;
        neg_reg  <= neg_next;
        zero_reg <= zero_next;
    end

`ifndef SYNTH
    a_zero_area_value: assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && res_zero) |-> (res_value == '0))
        else $error("zero area result carries a nonzero value");

    a_read_then_acc: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |=> (state_reg == S_ACC))
        else $error("corner read not followed by accumulate");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> ({1'b0, rem_reg} < {ds_reg, 1'b0}))
        else $error("divider remainder out of range");
`endif

endmodule
